>>> design/ldlt_pkg.sv
// ----------------------------------------------------------------------------
// ldlt_pkg
// Shared types, register map and constants of the load degradation tracker.
// ----------------------------------------------------------------------------
package ldlt_pkg;

  // fixed field widths
  localparam int IN_TICK_BITS = 64;
  localparam int PCT_BITS     = 7;
  localparam int PERSIST_BITS = 8;
  localparam int LEVEL_BITS   = 2;
  localparam int APB_ADDR_BITS = 5;
  localparam int APB_DATA_BITS = 32;

  // parameter defaults
  localparam int TICK_WIDTH_DEFAULT = 64;
  localparam int RUN_WIDTH_DEFAULT  = 8;

  // register indexes (byte address is four times the index)
  localparam logic [2:0] REG_HIGH_THR = 3'd0;
  localparam logic [2:0] REG_MID_THR  = 3'd1;
  localparam logic [2:0] REG_LOW_THR  = 3'd2;
  localparam logic [2:0] REG_REC_THR  = 3'd3;
  localparam logic [2:0] REG_PERSIST  = 3'd4;

  // register reset values
  localparam logic [PCT_BITS-1:0]     HIGH_THR_RESET = 7'd95;
  localparam logic [PCT_BITS-1:0]     MID_THR_RESET  = 7'd85;
  localparam logic [PCT_BITS-1:0]     LOW_THR_RESET  = 7'd70;
  localparam logic [PCT_BITS-1:0]     REC_THR_RESET  = 7'd60;
  localparam logic [PERSIST_BITS-1:0] PERSIST_RESET  = 8'd10;

  // busy share is scaled by this before comparing against threshold * all
  localparam logic [PCT_BITS-1:0] PERCENT_SCALE = 7'd100;

  // degradation levels
  localparam logic [LEVEL_BITS-1:0] LEVEL_NORMAL = 2'd0;
  localparam logic [LEVEL_BITS-1:0] LEVEL_LOW    = 2'd1;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MID    = 2'd2;
  localparam logic [LEVEL_BITS-1:0] LEVEL_HIGH   = 2'd3;

  typedef struct packed {
    logic [PCT_BITS-1:0]     high_thr;
    logic [PCT_BITS-1:0]     mid_thr;
    logic [PCT_BITS-1:0]     low_thr;
    logic [PCT_BITS-1:0]     rec_thr;
    logic [PERSIST_BITS-1:0] persist;
  } cfg_t;

endpackage

>>> design/ldlt_if.sv
// ----------------------------------------------------------------------------
// ldlt channel interfaces
// Valid/ready channels for tick samples and level results.
// ----------------------------------------------------------------------------
interface ldlt_sample_if
  import ldlt_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [IN_TICK_BITS-1:0] user_ticks;
  logic [IN_TICK_BITS-1:0] nice_ticks;
  logic [IN_TICK_BITS-1:0] system_ticks;
  logic [IN_TICK_BITS-1:0] idle_ticks;

  modport source (output valid, user_ticks, nice_ticks, system_ticks, idle_ticks,
                  input ready);
  modport sink (input valid, user_ticks, nice_ticks, system_ticks, idle_ticks,
                output ready);
endinterface

interface ldlt_result_if
  import ldlt_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] level;
  logic                  baseline_only;

  modport source (output valid, level, baseline_only, input ready);
  modport sink (input valid, level, baseline_only, output ready);
endinterface

>>> design/ldlt_regs.sv
// ----------------------------------------------------------------------------
// ldlt_regs
// APB register file holding thresholds and persistence count.
// ----------------------------------------------------------------------------
module ldlt_regs
  import ldlt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[APB_ADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_thr <= HIGH_THR_RESET;
      cfg.mid_thr  <= MID_THR_RESET;
      cfg.low_thr  <= LOW_THR_RESET;
      cfg.rec_thr  <= REC_THR_RESET;
      cfg.persist  <= PERSIST_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HIGH_THR: cfg.high_thr <= pwdata[PCT_BITS-1:0];
        REG_MID_THR:  cfg.mid_thr  <= pwdata[PCT_BITS-1:0];
        REG_LOW_THR:  cfg.low_thr  <= pwdata[PCT_BITS-1:0];
        REG_REC_THR:  cfg.rec_thr  <= pwdata[PCT_BITS-1:0];
        REG_PERSIST:  cfg.persist  <= pwdata[PERSIST_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_HIGH_THR: prdata = APB_DATA_BITS'(cfg.high_thr);
      REG_MID_THR:  prdata = APB_DATA_BITS'(cfg.mid_thr);
      REG_LOW_THR:  prdata = APB_DATA_BITS'(cfg.low_thr);
      REG_REC_THR:  prdata = APB_DATA_BITS'(cfg.rec_thr);
      REG_PERSIST:  prdata = APB_DATA_BITS'(cfg.persist);
      default:      prdata = '0;
    endcase
  end

endmodule

>>> design/ldlt_delta.sv
// ----------------------------------------------------------------------------
// ldlt_delta
// Input stage: keeps the previous sample and registers busy and all deltas.
// ----------------------------------------------------------------------------
module ldlt_delta
  import ldlt_pkg::*;
#(
  parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [TICK_WIDTH-1:0] user_ticks,
  input  logic [TICK_WIDTH-1:0] nice_ticks,
  input  logic [TICK_WIDTH-1:0] system_ticks,
  input  logic [TICK_WIDTH-1:0] idle_ticks,
  output logic                  out_valid,
  output logic                  live,
  output logic [TICK_WIDTH-1:0] busy,
  output logic [TICK_WIDTH-1:0] all_ticks
);

  logic [TICK_WIDTH-1:0] prev_user;
  logic [TICK_WIDTH-1:0] prev_nice;
  logic [TICK_WIDTH-1:0] prev_system;
  logic [TICK_WIDTH-1:0] prev_idle;
  logic [TICK_WIDTH-1:0] busy_next;
  logic [TICK_WIDTH-1:0] all_next;
  logic                  have_base;
  logic                  take;

  assign take = adv && in_valid;

  // wrapping deltas against the stored sample
  always_comb begin
    busy_next = (user_ticks - prev_user) + (nice_ticks - prev_nice)
              + (system_ticks - prev_system);
    all_next  = busy_next + (idle_ticks - prev_idle);
    have_base = |{prev_user, prev_nice, prev_system, prev_idle};
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  // previous sample, cleared so the first sample only sets the baseline
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_user   <= '0;
      prev_nice   <= '0;
      prev_system <= '0;
      prev_idle   <= '0;
    end else if (take) begin
      prev_user   <= user_ticks;
      prev_nice   <= nice_ticks;
      prev_system <= system_ticks;
      prev_idle   <= idle_ticks;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (take) begin
      busy      <= busy_next;
      all_ticks <= all_next;
      live      <= have_base && (all_next != '0);
    end
  end

endmodule

>>> design/ldlt_scale.sv
// ----------------------------------------------------------------------------
// ldlt_scale
// Product stage: busy times one hundred and all times each threshold.
// ----------------------------------------------------------------------------
module ldlt_scale
  import ldlt_pkg::*;
#(
  parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT,
  localparam int PROD_WIDTH = TICK_WIDTH + PCT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic                  in_live,
  input  logic [TICK_WIDTH-1:0] busy,
  input  logic [TICK_WIDTH-1:0] all_ticks,
  input  cfg_t                  cfg,
  output logic                  out_valid,
  output logic                  live,
  output logic [PROD_WIDTH-1:0] busy_scaled,
  output logic [PROD_WIDTH-1:0] high_prod,
  output logic [PROD_WIDTH-1:0] mid_prod,
  output logic [PROD_WIDTH-1:0] low_prod,
  output logic [PROD_WIDTH-1:0] rec_prod
);

  logic [PROD_WIDTH-1:0] busy_ext;
  logic [PROD_WIDTH-1:0] all_ext;
  logic                  take;

  assign take     = adv && in_valid;
  assign busy_ext = PROD_WIDTH'(busy);
  assign all_ext  = PROD_WIDTH'(all_ticks);

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  // exact products, full precision
  always_ff @(posedge clk) begin
    if (take) begin
      live        <= in_live;
      busy_scaled <= busy_ext * PROD_WIDTH'(PERCENT_SCALE);
      high_prod   <= all_ext * PROD_WIDTH'(cfg.high_thr);
      mid_prod    <= all_ext * PROD_WIDTH'(cfg.mid_thr);
      low_prod    <= all_ext * PROD_WIDTH'(cfg.low_thr);
      rec_prod    <= all_ext * PROD_WIDTH'(cfg.rec_thr);
    end
  end

endmodule

>>> design/ldlt_band.sv
// ----------------------------------------------------------------------------
// ldlt_band
// Band stage: picks the band, runs the persistence counters, holds the result.
// ----------------------------------------------------------------------------
module ldlt_band
  import ldlt_pkg::*;
#(
  parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT,
  parameter int RUN_WIDTH  = RUN_WIDTH_DEFAULT,
  localparam int PROD_WIDTH = TICK_WIDTH + PCT_BITS,
  localparam int CMP_WIDTH  = (RUN_WIDTH > PERSIST_BITS) ? RUN_WIDTH : PERSIST_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic                    in_live,
  input  logic [PROD_WIDTH-1:0]   busy_scaled,
  input  logic [PROD_WIDTH-1:0]   high_prod,
  input  logic [PROD_WIDTH-1:0]   mid_prod,
  input  logic [PROD_WIDTH-1:0]   low_prod,
  input  logic [PROD_WIDTH-1:0]   rec_prod,
  input  logic [PERSIST_BITS-1:0] persist,
  output logic                    out_valid,
  output logic [LEVEL_BITS-1:0]   out_level,
  output logic                    out_baseline_only,
  output logic [LEVEL_BITS-1:0]   current_level,
  output logic [3:0]              run_active
);

  localparam logic [RUN_WIDTH-1:0] RUN_MAX = {RUN_WIDTH{1'b1}};

  logic [RUN_WIDTH-1:0]  run [4];
  logic [RUN_WIDTH-1:0]  run_sel;
  logic [RUN_WIDTH-1:0]  run_inc;
  logic [RUN_WIDTH-1:0]  run_new;
  logic [LEVEL_BITS-1:0] sel;
  logic [LEVEL_BITS-1:0] level_next;
  logic                  hit;
  logic                  reach;
  logic                  take;

  assign take = adv && in_valid;

  // band select, highest band first
  always_comb begin
    hit = in_live;
    sel = LEVEL_NORMAL;
    if (busy_scaled > high_prod) begin
      sel = LEVEL_HIGH;
    end else if (busy_scaled > mid_prod) begin
      sel = LEVEL_MID;
    end else if (busy_scaled > low_prod) begin
      sel = LEVEL_LOW;
    end else if (busy_scaled < rec_prod) begin
      sel = LEVEL_NORMAL;
    end else begin
      hit = 1'b0;
    end
  end

  // saturating count and persistence check for the chosen band
  always_comb begin
    run_sel    = run[sel];
    run_inc    = (run_sel == RUN_MAX) ? run_sel : run_sel + 1'b1;
    reach      = CMP_WIDTH'(run_inc) >= CMP_WIDTH'(persist);
    run_new    = reach ? RUN_WIDTH'(persist) : run_inc;
    level_next = (hit && reach) ? sel : current_level;
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      current_level <= LEVEL_NORMAL;
      for (int j = 0; j < 4; j++) begin
        run[j] <= '0;
      end
    end else if (take && hit) begin
      current_level <= level_next;
      for (int j = 0; j < 4; j++) begin
        run[j] <= (LEVEL_BITS'(j) == sel) ? run_new : '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (take) begin
      out_level         <= level_next;
      out_baseline_only <= !in_live;
    end
  end

  // nonzero counter flags
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      run_active[j] = (run[j] != '0);
    end
  end

endmodule

>>> design/load_degradation_level_tracker_core.sv
// ----------------------------------------------------------------------------
// load_degradation_level_tracker_core
// Tracks a degradation level from cumulative cpu tick samples.
// ----------------------------------------------------------------------------
// path: a sample passes the delta, scale and band stage registers, and its
//   result is valid once it is in the band stage's result register
// throughput: one sample per cycle; each stage moves unless the stage
//   after it is full and stalled, so empty stages fill while a result waits
// reset: synchronous; thresholds return to 95/85/70/60, persistence to 10,
//   the stored sample, run counters and level clear, the pipeline empties
module load_degradation_level_tracker_core
  import ldlt_pkg::*;
#(
  parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT,
  parameter int RUN_WIDTH  = RUN_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  ldlt_sample_if.sink              sample,
  ldlt_result_if.source            result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int PROD_WIDTH = TICK_WIDTH + PCT_BITS;

  cfg_t                  cfg;
  logic                  adv1;
  logic                  adv2;
  logic                  adv3;
  logic                  s1_valid;
  logic                  s1_live;
  logic [TICK_WIDTH-1:0] s1_busy;
  logic [TICK_WIDTH-1:0] s1_all;
  logic                  s2_valid;
  logic                  s2_live;
  logic [PROD_WIDTH-1:0] s2_busy_scaled;
  logic [PROD_WIDTH-1:0] s2_high;
  logic [PROD_WIDTH-1:0] s2_mid;
  logic [PROD_WIDTH-1:0] s2_low;
  logic [PROD_WIDTH-1:0] s2_rec;
  logic [LEVEL_BITS-1:0] current_level;
  logic [3:0]            run_active;

  // stage advance, back from the output
  assign adv3 = !result.valid || result.ready;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;
  assign sample.ready = adv1;

  ldlt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ldlt_delta #(.TICK_WIDTH(TICK_WIDTH)) u_delta (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv1),
    .in_valid     (sample.valid),
    .user_ticks   (sample.user_ticks[TICK_WIDTH-1:0]),
    .nice_ticks   (sample.nice_ticks[TICK_WIDTH-1:0]),
    .system_ticks (sample.system_ticks[TICK_WIDTH-1:0]),
    .idle_ticks   (sample.idle_ticks[TICK_WIDTH-1:0]),
    .out_valid    (s1_valid),
    .live         (s1_live),
    .busy         (s1_busy),
    .all_ticks    (s1_all)
  );

  ldlt_scale #(.TICK_WIDTH(TICK_WIDTH)) u_scale (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv2),
    .in_valid    (s1_valid),
    .in_live     (s1_live),
    .busy        (s1_busy),
    .all_ticks   (s1_all),
    .cfg         (cfg),
    .out_valid   (s2_valid),
    .live        (s2_live),
    .busy_scaled (s2_busy_scaled),
    .high_prod   (s2_high),
    .mid_prod    (s2_mid),
    .low_prod    (s2_low),
    .rec_prod    (s2_rec)
  );

  ldlt_band #(.TICK_WIDTH(TICK_WIDTH), .RUN_WIDTH(RUN_WIDTH)) u_band (
    .clk               (clk),
    .rst               (rst),
    .adv               (adv3),
    .in_valid          (s2_valid),
    .in_live           (s2_live),
    .busy_scaled       (s2_busy_scaled),
    .high_prod         (s2_high),
    .mid_prod          (s2_mid),
    .low_prod          (s2_low),
    .rec_prod          (s2_rec),
    .persist           (cfg.persist),
    .out_valid         (result.valid),
    .out_level         (result.level),
    .out_baseline_only (result.baseline_only),
    .current_level     (current_level),
    .run_active        (run_active)
  );

  // a shown result always carries the tracker's present level
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.level == current_level)
    else $error("result level differs from tracked level");

  // entering a band clears the other counters
  assert property (@(posedge clk) disable iff (rst)
    $countones(run_active) <= 1)
    else $error("more than one band counter is running");

  // input stalls only when every stage is full
  assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> s1_valid && s2_valid && result.valid)
    else $error("input stalled with an empty stage");

  // level changes only when the band stage takes a sample
  assert property (@(posedge clk) disable iff (rst)
    !(adv3 && s2_valid) |=> $stable(current_level))
    else $error("level changed without a sample");

endmodule
